// ===== hdl/pyramid_layer_encoder_defines.svh =====
// Assertion macros shared by the pyramid layer encoder modules.
`ifndef PYRAMID_LAYER_ENCODER_DEFINES_SVH
`define PYRAMID_LAYER_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PLENC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PLENC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/plenc_pkg.sv =====
// Shared constants, types and register codes of the pyramid layer encoder.
`timescale 1ns / 1ps

package plenc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int SAMPLE_W  = 16;
    localparam int COORD_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = SAMPLE_W + 2;
    localparam int IDX_W     = 3;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // Positions inside the result tuser.
    localparam int USER_KIND_BIT = 0;
    localparam int USER_FEND_BIT = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_PARENT   = 1'b1;

    // Shape of the block that a sample completes.
    typedef enum logic [2:0] {
        BLK_NONE,
        BLK_ONE,
        BLK_ROW2,
        BLK_COL2,
        BLK_QUAD
    } blk_t;

    typedef struct packed {
        blk_t                blk;
        logic [SAMPLE_W-1:0] cur;
        logic [SAMPLE_W-1:0] left;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                frame_end;
    } scan_item_t;

endpackage

// ===== hdl/plenc_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module plenc_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/plenc_scan.sv =====
// Raster position tracking, size registers and line store access.
`timescale 1ns / 1ps
`include "pyramid_layer_encoder_defines.svh"

module plenc_scan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plenc_pkg::DIM_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [plenc_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                st_we,
    output logic [plenc_pkg::COORD_W-1:0]       st_waddr,
    output logic [plenc_pkg::SAMPLE_W-1:0]      st_wdata,
    output logic                                st_re,
    output logic [plenc_pkg::COORD_W-1:0]       st_raddr,
    output logic                                item_valid,
    output plenc_pkg::scan_item_t               item,
    input  logic                                item_take
);

    localparam int DW = plenc_pkg::DIM_W;
    localparam int CW = plenc_pkg::COORD_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                                input logic [DW-1:0] maxv);
        logic [DW-1:0] r;
        r = v;
        if (v == '0) begin
            r = DW'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    logic [DW-1:0] w_reg;
    logic [DW-1:0] h_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [plenc_pkg::SAMPLE_W-1:0] left_reg;
    logic          s1_valid_reg;
    plenc_pkg::scan_item_t item_reg, item_next;

    logic          accept;
    logic          col_wrap;
    logic [DW-1:0] row_step;
    logic [CW-1:0] x, y;
    logic          x_last, y_last;
    logic [plenc_pkg::SAMPLE_W-1:0] cur;

    assign cfg_ready = 1'b1;
    assign s_tready  = !s1_valid_reg || item_take;
    assign accept    = s_tvalid && s_tready;
    assign cur       = s_tdata[plenc_pkg::SAMPLE_W-1:0];

    always_comb begin
        // A size change while mid-layer can leave the counters past the edge.
        col_wrap = {1'b0, col_reg} >= w_reg;
        row_step = {1'b0, row_reg} + DW'(col_wrap);
        x        = col_wrap ? '0 : col_reg;
        y        = (row_step >= h_reg) ? '0 : row_step[CW-1:0];
        x_last   = ({1'b0, x} + DW'(1)) >= w_reg;
        y_last   = ({1'b0, y} + DW'(1)) >= h_reg;

        if (x_last) begin
            col_next = '0;
            row_next = y_last ? '0 : y + CW'(1);
        end else begin
            col_next = x + CW'(1);
            row_next = y;
        end

        item_next.blk = plenc_pkg::BLK_NONE;
        if (!y[0]) begin
            if (y_last) begin
                if (x[0]) begin
                    item_next.blk = plenc_pkg::BLK_ROW2;
                end else if (x_last) begin
                    item_next.blk = plenc_pkg::BLK_ONE;
                end
            end
        end else begin
            if (x[0]) begin
                item_next.blk = plenc_pkg::BLK_QUAD;
            end else if (x_last) begin
                item_next.blk = plenc_pkg::BLK_COL2;
            end
        end
        item_next.cur       = cur;
        item_next.left      = left_reg;
        item_next.x         = x;
        item_next.y         = y;
        item_next.frame_end = x_last && y_last;
    end

    // Even rows fill the line store; odd rows read the sample above.
    assign st_we    = accept && !y[0];
    assign st_waddr = x;
    assign st_wdata = cur;
    assign st_re    = accept && y[0];
    assign st_raddr = x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= DW'(plenc_pkg::MAX_WIDTH);
            h_reg        <= DW'(plenc_pkg::MAX_HEIGHT);
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == plenc_pkg::REG_IMAGE_WIDTH) begin
                    w_reg <= clamp_dim(cfg_data, DW'(plenc_pkg::MAX_WIDTH));
                end else if (cfg_index == plenc_pkg::REG_IMAGE_HEIGHT) begin
                    h_reg <= clamp_dim(cfg_data, DW'(plenc_pkg::MAX_HEIGHT));
                end
            end
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                left_reg     <= cur;
                s1_valid_reg <= 1'b1;
            end else if (item_take) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = item_reg;

    `PLENC_ASSERT_IMP(a_frame_end_closes_block,
        s1_valid_reg && item_reg.frame_end, item_reg.blk != plenc_pkg::BLK_NONE,
        "frame end on a sample that completes no block")
    `PLENC_ASSERT_IMP(a_quad_at_odd_corner,
        s1_valid_reg && item_reg.blk == plenc_pkg::BLK_QUAD,
        item_reg.x[0] && item_reg.y[0],
        "full block completed away from an odd column and row")

endmodule

// ===== hdl/plenc_emit.sv =====
// Block mean, residual sequencing and the result output register.
`timescale 1ns / 1ps
`include "pyramid_layer_encoder_defines.svh"

module plenc_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_valid,
    input  plenc_pkg::scan_item_t               item,
    output logic                                item_take,
    input  logic [plenc_pkg::SAMPLE_W-1:0]      st_rdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [plenc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic [plenc_pkg::M_USER_W-1:0]      m_tuser
);

    localparam int SW = plenc_pkg::SAMPLE_W;
    localparam int CW = plenc_pkg::COORD_W;
    localparam int UW = plenc_pkg::SUM_W;
    localparam int IW = plenc_pkg::IDX_W;

    logic [SW-1:0] top_prev_reg;

    logic          s2_valid_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] mean_reg, mean_next;
    logic          fe_reg;
    logic [CW-1:0] px_reg, py_reg;
    logic [SW-1:0] vals_reg [4];
    logic [CW-1:0] xs_reg [4];
    logic [CW-1:0] ys_reg [4];
    logic [SW-1:0] vals_next [4];
    logic [CW-1:0] xs_next [4];
    logic [CW-1:0] ys_next [4];

    logic                       m_valid_reg;
    logic [plenc_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;
    logic [plenc_pkg::M_USER_W-1:0] m_user_reg, m_user_next;

    logic          out_free, emit_fire, s2_done, s2_free, item_none, s2_load;
    logic [CW-1:0] bx, by;
    logic [UW-1:0] sum;
    logic [1:0]    shift;
    logic [1:0]    res_sel;
    logic [SW-1:0] res_val;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_fire = s2_valid_reg && out_free;
    assign s2_done   = emit_fire && (idx_reg == cnt_reg);
    assign s2_free   = !s2_valid_reg || s2_done;
    assign item_none = item.blk == plenc_pkg::BLK_NONE;
    assign item_take = item_valid && (item_none || s2_free);
    assign s2_load   = item_take && !item_none;

    always_comb begin
        bx = {item.x[CW-1:1], 1'b0};
        by = {item.y[CW-1:1], 1'b0};
        for (int i = 0; i < 4; i++) begin
            vals_next[i] = '0;
            xs_next[i]   = item.x;
            ys_next[i]   = item.y;
        end
        cnt_next = '0;
        shift    = 2'd0;
        case (item.blk)
            plenc_pkg::BLK_ONE: begin
                vals_next[0] = item.cur;
                cnt_next     = IW'(1);
            end
            plenc_pkg::BLK_ROW2: begin
                vals_next[0] = item.left;
                xs_next[0]   = bx;
                vals_next[1] = item.cur;
                cnt_next     = IW'(2);
                shift        = 2'd1;
            end
            plenc_pkg::BLK_COL2: begin
                vals_next[0] = st_rdata;
                ys_next[0]   = by;
                vals_next[1] = item.cur;
                cnt_next     = IW'(2);
                shift        = 2'd1;
            end
            plenc_pkg::BLK_QUAD: begin
                // The top-left sample was read for the previous beat of this row.
                vals_next[0] = top_prev_reg;
                xs_next[0]   = bx;
                ys_next[0]   = by;
                vals_next[1] = st_rdata;
                ys_next[1]   = by;
                vals_next[2] = item.left;
                xs_next[2]   = bx;
                vals_next[3] = item.cur;
                cnt_next     = IW'(4);
                shift        = 2'd2;
            end
            default: begin
                cnt_next = '0;
            end
        endcase
        // Rounding adds half the sample count before the shift.
        sum = UW'(vals_next[0]) + UW'(vals_next[1]) + UW'(vals_next[2])
            + UW'(vals_next[3]) + UW'(cnt_next[IW-1:1]);
        mean_next = SW'(sum >> shift);
    end

    always_comb begin
        res_sel = 2'(idx_reg - IW'(1));
        res_val = vals_reg[res_sel] - mean_reg;
        if (idx_reg == '0) begin
            m_data_next = {mean_reg, py_reg, px_reg};
            m_user_next = {fe_reg, plenc_pkg::KIND_PARENT};
        end else begin
            m_data_next = {res_val, ys_reg[res_sel], xs_reg[res_sel]};
            m_user_next = {fe_reg, plenc_pkg::KIND_RESIDUAL};
        end
        m_last_next = idx_reg == cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s2_load) begin
                s2_valid_reg <= 1'b1;
                idx_reg      <= '0;
            end else if (s2_done) begin
                s2_valid_reg <= 1'b0;
            end else if (emit_fire) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && item.y[0]) begin
            top_prev_reg <= st_rdata;
        end
        if (s2_load) begin
            cnt_reg  <= cnt_next;
            mean_reg <= mean_next;
            fe_reg   <= item.frame_end;
            px_reg   <= {1'b0, item.x[CW-1:1]};
            py_reg   <= {1'b0, item.y[CW-1:1]};
            for (int i = 0; i < 4; i++) begin
                vals_reg[i] <= vals_next[i];
                xs_reg[i]   <= xs_next[i];
                ys_reg[i]   <= ys_next[i];
            end
        end
        if (emit_fire) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    `PLENC_ASSERT_IMP(a_idx_in_range, s2_valid_reg, idx_reg <= cnt_reg,
        "result index ran past the block's sample count")
    `PLENC_ASSERT_NXT(a_parent_first, s2_load, s2_valid_reg && idx_reg == '0,
        "new block does not start with its parent beat")
    `PLENC_ASSERT_IMP(a_parent_not_last,
        m_valid_reg && m_user_reg[plenc_pkg::USER_KIND_BIT] == plenc_pkg::KIND_PARENT,
        !m_last_reg, "parent beat flagged as the last result of a block")

endmodule

// ===== hdl/pyramid_layer_encoder.sv =====
// Top level of the 2x2 mean pyramid layer encoder.
`timescale 1ns / 1ps
// Samples of one layer enter in raster order on the s_ channel, one per beat
// in s_tdata[15:0]. The cfg channel writes image_width (index 0) and
// image_height (index 1); it is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this. Each
// sample that completes a 2x2 block (clipped at an odd right or bottom edge)
// yields one parent beat with the rounded mean, then one residual beat per
// sample of the block: 2 to 5 beats, m_tlast on the final one. Other samples
// yield no beat. m_tuser carries kind and the frame-end flag. The parent beat
// passes the scan item, block and output registers after its sample is
// accepted; the block then drives one result per cycle while m_tready allows.
// Samples that complete no block are taken every cycle unless one that does
// waits ahead; each block holds the shared result sequencer for its beats.
// The line store is one 4096-entry RAM, written on even rows and read on odd
// rows at one address per sample; its read result is kept for the next sample.
// Reset clears the position counters, restores full size and empties the
// pipeline; the line store is not cleared. When m_tready is low, the output
// register holds its beat and s_tready drops once the pipeline is full.

module pyramid_layer_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plenc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plenc_pkg::DIM_W-1:0]     cfg_data,
    // Input samples.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plenc_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] sample
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plenc_pkg::M_DATA_W-1:0]  m_tdata,   // [11:0] pos_x, [23:12] pos_y,
                                                       // [39:24] value
    output logic                            m_tlast,
    output logic [plenc_pkg::M_USER_W-1:0]  m_tuser    // [0] kind, [1] frame_end
);

    logic                               st_we;
    logic [plenc_pkg::COORD_W-1:0]      st_waddr;
    logic [plenc_pkg::SAMPLE_W-1:0]     st_wdata;
    logic                               st_re;
    logic [plenc_pkg::COORD_W-1:0]      st_raddr;
    logic [plenc_pkg::SAMPLE_W-1:0]     st_rdata;
    logic                               item_valid;
    plenc_pkg::scan_item_t              item;
    logic                               item_take;

    plenc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_re      (st_re),
        .st_raddr   (st_raddr),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    plenc_ram #(
        .ADDR_W (plenc_pkg::COORD_W),
        .DATA_W (plenc_pkg::SAMPLE_W)
    ) u_line_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    plenc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .st_rdata   (st_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== verif/pyramid_layer_encoder_tb.sv =====
// Self-checking testbench for the 2x2 mean pyramid layer encoder.
`timescale 1ns / 1ps

module pyramid_layer_encoder_tb;

    import plenc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SAMPLES = 420;
    localparam int PRINT_LIMIT    = 100;
    localparam int WIDE_ROW       = 40;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [SAMPLE_W-1:0] value;
        logic                last;
        logic                frame_end;
    } enc_beat_t;

    // Tracks the encoder state and queues the parent and residual beats that
    // each accepted sample must produce.
    class mean_residual_scoreboard;
        logic [SAMPLE_W-1:0] line_store [MAX_WIDTH];
        bit                  line_written [MAX_WIDTH];
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        logic [SAMPLE_W-1:0] left_sample;
        int unsigned         column;
        int unsigned         row;
        enc_beat_t           pending_beats [$];
        int                  failures;
        int                  samples;
        int                  beats;
        int                  layers;

        function new();
            width_reg   = DIM_W'(MAX_WIDTH);
            height_reg  = DIM_W'(MAX_HEIGHT);
            left_sample = '0;
            column      = 0;
            row         = 0;
            failures    = 0;
            samples     = 0;
            beats       = 0;
            layers      = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function logic [SAMPLE_W-1:0] stored(int unsigned addr);
            if (!line_written[addr]) begin
                failures++;
                $display("%0t: line store entry %0d read before any write", $time, addr);
            end
            return line_store[addr];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = data;
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = data;
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] cur);
            int unsigned         w, h, x, y, bx, by, n, sum, shift;
            int unsigned         xs [4];
            int unsigned         ys [4];
            logic [SAMPLE_W-1:0] vals [4];
            logic [SAMPLE_W-1:0] mean;
            enc_beat_t           beat;
            bit                  fend;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            samples++;
            // A size written mid-layer can leave the position outside the layer.
            if (column >= w) begin
                column = 0;
                row++;
            end
            if (row >= h) row = 0;
            x = column;
            y = row;
            bx = x - (x % 2);
            by = y - (y % 2);
            n = 0;
            if (y % 2 == 0) begin
                line_store[x] = cur;
                line_written[x] = 1'b1;
                if (y + 1 >= h) begin
                    if (x % 2 == 1) begin
                        vals[0] = left_sample; xs[0] = bx; ys[0] = y;
                        vals[1] = cur;         xs[1] = x;  ys[1] = y;
                        n = 2;
                    end else if (x + 1 >= w) begin
                        vals[0] = cur; xs[0] = x; ys[0] = y;
                        n = 1;
                    end
                end
            end else if (x % 2 == 1) begin
                vals[0] = stored(bx);  xs[0] = bx; ys[0] = by;
                vals[1] = stored(x);   xs[1] = x;  ys[1] = by;
                vals[2] = left_sample; xs[2] = bx; ys[2] = y;
                vals[3] = cur;         xs[3] = x;  ys[3] = y;
                n = 4;
            end else if (x + 1 >= w) begin
                vals[0] = stored(x); xs[0] = x; ys[0] = by;
                vals[1] = cur;       xs[1] = x; ys[1] = y;
                n = 2;
            end

            if (n != 0) begin
                shift = (n == 4) ? 2 : ((n == 2) ? 1 : 0);
                sum = n / 2;
                for (int i = 0; i < n; i++) sum += vals[i];
                mean = SAMPLE_W'(sum >> shift);
                fend = (x + 1 >= w) && (y + 1 >= h);
                beat.kind      = KIND_PARENT;
                beat.pos_x     = COORD_W'(bx / 2);
                beat.pos_y     = COORD_W'(by / 2);
                beat.value     = mean;
                beat.last      = 1'b0;
                beat.frame_end = fend;
                pending_beats.push_back(beat);
                for (int i = 0; i < n; i++) begin
                    beat.kind  = KIND_RESIDUAL;
                    beat.pos_x = COORD_W'(xs[i]);
                    beat.pos_y = COORD_W'(ys[i]);
                    beat.value = vals[i] - mean;
                    beat.last  = (i == n - 1);
                    pending_beats.push_back(beat);
                end
            end

            left_sample = cur;
            column = x + 1;
            row = y;
            if (column >= w) begin
                column = 0;
                row = y + 1;
                if (row >= h) row = 0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= PRINT_LIMIT)
                    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                             $time, name, want, got);
            end
        endfunction

        function void match_beat(enc_beat_t got);
            enc_beat_t want;
            beats++;
            if (pending_beats.size() == 0) begin
                failures++;
                if (failures <= PRINT_LIMIT)
                    $display("%0t: unexpected result beat, expected none, got 0x%0h",
                             $time, got);
                return;
            end
            want = pending_beats.pop_front();
            if (want.last && want.frame_end) layers++;
            compare_field("kind", want.kind, got.kind);
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("value", want.value, got.value);
            compare_field("last", want.last, got.last);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [M_USER_W-1:0]   m_tuser;

    mean_residual_scoreboard board;

    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int hold_request  = 0;

    logic [SAMPLE_W-1:0] corner_quad [4] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
    logic [SAMPLE_W-1:0] odd_grid [9] = '{16'h0001, 16'hFFFE, 16'h7FFF,
                                          16'h8000, 16'h0003, 16'hFFFF,
                                          16'h0000, 16'h0001, 16'hFFFF};
    logic [SAMPLE_W-1:0] single_pair [2] = '{16'hFFFF, 16'h0000};

    pyramid_layer_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        enc_beat_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser[USER_KIND_BIT];
                got.pos_x     = m_tdata[COORD_W-1:0];
                got.pos_y     = m_tdata[2*COORD_W-1:COORD_W];
                got.value     = m_tdata[M_DATA_W-1:2*COORD_W];
                got.last      = m_tlast;
                got.frame_end = m_tuser[USER_FEND_BIT];
                board.match_beat(got);
            end
            if (s_tvalid && s_tready) board.take_sample(s_tdata[SAMPLE_W-1:0]);
        end
    end

    // The receiver follows a 16-bit ready pattern that changes now and then,
    // and honors a long hold-off when the stimulus asks for one.
    initial begin : receiver
        int          hold_left;
        int          tick;
        logic [15:0] pattern;
        hold_left = 0;
        tick = 0;
        pattern = 16'hFFFF;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (tick % 48 == 0)
                pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= pattern[tick % 16];
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[pyramid_layer_encoder] ERROR");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 ^ 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic configure(input int w, input int h);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= DIM_W'(w);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
        int gap;
        s_tdata  <= S_DATA_W'(sample);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (steady_sender) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop sending, collect every outstanding beat, then give samples that
    // produce nothing time to leave the pipeline.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (board.pending_beats.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin : stimulus
        int random_count;
        int w;
        int h;
        int count;
        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        configure(2, 2);
        foreach (corner_quad[i]) push_sample(corner_quad[i]);
        finish_phase();

        // Odd sizes give a full block, a right-edge column pair, a bottom row
        // pair and a lone corner sample.
        configure(3, 3);
        foreach (odd_grid[i]) push_sample(odd_grid[i]);
        finish_phase();

        // Zero sizes behave as a 1x1 layer, so every sample ends a layer.
        configure(0, 0);
        foreach (single_pair[i]) push_sample(single_pair[i]);
        finish_phase();

        // Narrow the layer while the position sits past the new right edge.
        configure(4, 2);
        repeat (6) push_sample(random_sample());
        finish_phase();
        configure(2, 2);
        repeat (4) push_sample(random_sample());
        finish_phase();

        // Oversized sizes clamp to the maximum. The wide row also fills every
        // line store entry that the later layers read.
        configure(8191, 1);
        repeat (WIDE_ROW) push_sample(random_sample());
        finish_phase();
        configure(1, 8191);
        repeat (WIDE_ROW) push_sample(random_sample());
        finish_phase();

        // Hold the output off while samples keep coming so the input backs up.
        configure(8, 8);
        steady_sender = 1'b1;
        hold_request = 400;
        repeat (64) push_sample(random_sample());
        steady_sender = 1'b0;
        finish_phase();
        random_count = board.samples;

        while (random_count < RANDOM_SAMPLES) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 5) == 0) begin
                w = $urandom_range(9, WIDE_ROW);
                h = $urandom_range(1, 3);
            end
            configure(w, h);
            steady_sender = ($urandom_range(0, 3) == 0);
            count = w * h * $urandom_range(1, 2);
            // Sometimes stop part way so the next size takes effect mid-layer.
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
            repeat (count) push_sample(random_sample());
            random_count += count;
            steady_sender = 1'b0;
            finish_phase();
        end

        repeat (20) @(posedge aclk);
        $display("Checked %0d samples, %0d result beats and %0d completed layers.",
                 board.samples, board.beats, board.layers);
        $display("Layers ran from 1x1 up to 40 wide, with zero and oversized sizes, mid-layer resizes and a long output stall.");
        if (board.failures == 0) begin
            $display("[pyramid_layer_encoder] OK");
        end else begin
            $display("%0d check failures", board.failures);
            $display("[pyramid_layer_encoder] ERROR");
        end
        $finish;
    end

endmodule
